/* rtl/c1ks_pkg.sv */
// Package for the Crypto-1 keystream engine: command codes, filter tables,
// LFSR taps and the bit-step and byte-step functions.
// No dependencies.
package c1ks_pkg;

    localparam int STATE_W = 48;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 4;

    // Filter tables
    localparam logic [15:0] TAB_F4A = 16'h9E98;
    localparam logic [15:0] TAB_F4B = 16'hB48E;
    localparam logic [31:0] TAB_F5C = 32'hEC57_E80A;

    // Feedback taps 0,5,9,10,12,14,15,17,19,24,25,27,29,35,39,41,42,43
    localparam logic [STATE_W-1:0] FB_TAPS = 48'h0E88_2B0A_D621;

    localparam logic [CNT_W-1:0] BYTE_BITS = 4'd8;

    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_BIT   = 3'd1,
        CMD_BYTE  = 3'd2,
        CMD_WORD  = 3'd3,
        CMD_CBYTE = 3'd4,
        CMD_CBITS = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [STATE_W-1:0] st;
        logic [7:0]         ks;
    } step_t;

    // Four index bits, two apart, first one as the LSB
    function automatic logic [3:0] nib(input logic [STATE_W-1:0] s, input int first);
        nib = {s[first+6], s[first+4], s[first+2], s[first]};
    endfunction

    function automatic logic filter(input logic [STATE_W-1:0] s);
        logic [4:0] idx;
        idx[0] = TAB_F4B[nib(s, 9)];
        idx[1] = TAB_F4A[nib(s, 17)];
        idx[2] = TAB_F4A[nib(s, 25)];
        idx[3] = TAB_F4B[nib(s, 33)];
        idx[4] = TAB_F4A[nib(s, 41)];
        filter = TAB_F5C[idx];
    endfunction

    // Clock up to eight times; input bits LSB first, keystream bits unused beyond n
    function automatic step_t clock_bits(input logic [STATE_W-1:0] s,
                                         input logic [7:0]         din,
                                         input logic               fb,
                                         input logic [CNT_W-1:0]   n);
        step_t      r;
        logic       ks;
        logic       nb;
        r.st = s;
        r.ks = '0;
        for (int i = 0; i < 8; i++) begin
            if (CNT_W'(i) < n) begin
                ks = filter(r.st);
                nb = (^(r.st & FB_TAPS)) ^ din[i] ^ (fb & ks);
                r.ks[i] = ks;
                r.st = {nb, r.st[STATE_W-1:1]};
            end
        end
        clock_bits = r;
    endfunction

endpackage

/* rtl/c1ks_core.sv */
// Crypto-1 command datapath: next LFSR state and result for one command.
// Purely combinational; depends on c1ks_pkg.
module c1ks_core (
    input  logic [c1ks_pkg::STATE_W-1:0] state_in,
    input  c1ks_pkg::cmd_t               command,
    input  logic [c1ks_pkg::DATA_W-1:0]  data_in,
    input  logic                         feedback,
    input  logic [c1ks_pkg::CNT_W-1:0]   bit_count,
    input  logic [c1ks_pkg::STATE_W-1:0] load_value,
    output logic [c1ks_pkg::STATE_W-1:0] state_out,
    output logic [c1ks_pkg::DATA_W-1:0]  data_out
);
    import c1ks_pkg::*;

    step_t            b3, b2, b1, b0;
    step_t            sb;
    logic [CNT_W-1:0] n_sat;
    logic             par;

    assign n_sat = (bit_count > BYTE_BITS) ? BYTE_BITS : bit_count;

    // Word: most significant byte first, chained through the state
    assign b3 = clock_bits(state_in, data_in[31:24], feedback, BYTE_BITS);
    assign b2 = clock_bits(b3.st,    data_in[23:16], feedback, BYTE_BITS);
    assign b1 = clock_bits(b2.st,    data_in[15:8],  feedback, BYTE_BITS);
    assign b0 = clock_bits(b1.st,    data_in[7:0],   feedback, BYTE_BITS);

    always_comb begin
        case (command)
            CMD_BIT:   sb = clock_bits(state_in, {7'd0, data_in[0]}, feedback, CNT_W'(1));
            CMD_BYTE:  sb = clock_bits(state_in, data_in[7:0], feedback, BYTE_BITS);
            CMD_CBYTE: sb = clock_bits(state_in, 8'd0, 1'b0, BYTE_BITS);
            CMD_CBITS: sb = clock_bits(state_in, 8'd0, 1'b0, n_sat);
            default:   sb = '{st: state_in, ks: 8'd0};
        endcase
    end

    // Parity keystream bit: filter of the stepped state, no clock
    assign par = filter(sb.st);

    always_comb begin
        case (command)
            CMD_LOAD: begin
                state_out = load_value;
                data_out  = '0;
            end
            CMD_BIT: begin
                state_out = sb.st;
                data_out  = {31'd0, sb.ks[0]};
            end
            CMD_BYTE: begin
                state_out = sb.st;
                data_out  = {24'd0, sb.ks};
            end
            CMD_WORD: begin
                state_out = b0.st;
                data_out  = {b3.ks, b2.ks, b1.ks, b0.ks};
            end
            CMD_CBYTE: begin
                state_out = sb.st;
                data_out  = {23'd0, par ^ data_in[8], sb.ks ^ data_in[7:0]};
            end
            CMD_CBITS: begin
                state_out = sb.st;
                data_out  = {24'd0, sb.ks ^ data_in[7:0]};
            end
            default: begin
                state_out = state_in;
                data_out  = '0;
            end
        endcase
    end

endmodule

/* rtl/crypto1_keystream_engine.sv */
// Crypto-1 keystream engine top level: input register, LFSR state register,
// result register. Depends on c1ks_pkg and c1ks_core.
// An accepted command passes through the input register and then the result register,
// which holds it until m_tready; m_tvalid is driven by the result register.
// Throughput: one command per cycle while m_tready keeps the result side free; each
// command, up to a 32-bit word, is done combinationally by the unrolled LFSR steps of c1ks_core.
// Reset (aresetn low, synchronous) clears both valid flags and the LFSR state.
module crypto1_keystream_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // data_in[31:0], feedback[32], bit_count[36:33],
                                  // load_value[84:37], zero pad[87:85]
    input  logic [2:0]  s_tuser,  // command[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // data_out[31:0]
);
    import c1ks_pkg::*;

    logic                in_valid_reg;
    logic [2:0]          cmd_reg;
    logic [DATA_W-1:0]   data_reg;
    logic                fb_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [STATE_W-1:0]  load_reg;

    logic [STATE_W-1:0]  state_reg, state_next;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;

    logic                out_free;
    logic                advance;
    logic                in_xfer;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_xfer  = s_tvalid && s_tready;

    c1ks_core u_core (
        .state_in   (state_reg),
        .command    (cmd_t'(cmd_reg)),
        .data_in    (data_reg),
        .feedback   (fb_reg),
        .bit_count  (cnt_reg),
        .load_value (load_reg),
        .state_out  (state_next),
        .data_out   (out_data_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg  <= s_tuser;
            data_reg <= s_tdata[31:0];
            fb_reg   <= s_tdata[32];
            cnt_reg  <= s_tdata[36:33];
            load_reg <= s_tdata[84:37];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (out_free) begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/c1ks_checker.sv */
// Port-level checks for the Crypto-1 keystream engine, bound to the top level.
// Sees only the top-level ports; no package dependency.
module c1ks_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // No result right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Input side only backs up when the output side is stalled
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input not ready without output stall");

    // An accepted command reaches the output when the sink is ready
    a_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("accepted command did not produce a result");

endmodule

bind crypto1_keystream_engine c1ks_checker u_c1ks_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/crypto1_keystream_engine_tb.sv */
// Testbench for crypto1_keystream_engine: directed command table, then random commands,
// each result checked against an in-bench Crypto-1 LFSR/filter predictor or a pinned value.
// Depends on c1ks_pkg (command codes) and the crypto1_keystream_engine RTL.
module crypto1_keystream_engine_tb;
    import c1ks_pkg::*;

    localparam logic [2:0]  CMD_UNUSED6 = 3'd6;
    localparam logic [2:0]  CMD_UNUSED7 = 3'd7;
    localparam logic [15:0] F4A_LUT = 16'h9E98;
    localparam logic [15:0] F4B_LUT = 16'hB48E;
    localparam logic [31:0] F5C_LUT = 32'hEC57_E80A;
    localparam int          MAX_CIPHER_BITS = 8;
    localparam int          NUM_RANDOM = 1300;
    localparam int          NUM_QUIET = 200;
    localparam int          MAX_REPORTS = 10;
    localparam int          DRAIN_LIMIT = 2000;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] data;
        logic        fb;
        logic [3:0]  cnt;
        logic [47:0] ld;
        bit          pinned;       // result is known by inspection
        logic [31:0] pinned_out;
    } cmd_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;   // data_in[31:0], feedback[32], bit_count[36:33],
                            // load_value[84:37], zero pad[87:85]
    logic [2:0]  s_tuser;   // command[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // data_out[31:0]

    logic [47:0] lfsr_model;
    logic [31:0] keystream_q[$];
    logic [31:0] want_out;
    bit          quiet;
    int          fail_cnt;
    int          results_seen;
    int          sent_cnt;
    int          cmd_hits[8];

    crypto1_keystream_engine u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic logic [3:0] filt_index(input logic [47:0] s, input int lo);
        return {s[lo+6], s[lo+4], s[lo+2], s[lo]};
    endfunction

    function automatic logic crypto_filter(input logic [47:0] s);
        logic [4:0] sel;
        sel[0] = F4B_LUT[filt_index(s, 9)];
        sel[1] = F4A_LUT[filt_index(s, 17)];
        sel[2] = F4A_LUT[filt_index(s, 25)];
        sel[3] = F4B_LUT[filt_index(s, 33)];
        sel[4] = F4A_LUT[filt_index(s, 41)];
        return F5C_LUT[sel];
    endfunction

    // One LFSR clock on lfsr_model; returns the keystream bit of the old state
    function automatic logic lfsr_step(input logic in_bit, input logic fb_en);
        logic ks;
        logic nb;
        ks = crypto_filter(lfsr_model);
        nb = lfsr_model[0] ^ lfsr_model[5] ^ lfsr_model[9] ^ lfsr_model[10] ^
             lfsr_model[12] ^ lfsr_model[14] ^ lfsr_model[15] ^ lfsr_model[17] ^
             lfsr_model[19] ^ lfsr_model[24] ^ lfsr_model[25] ^ lfsr_model[27] ^
             lfsr_model[29] ^ lfsr_model[35] ^ lfsr_model[39] ^ lfsr_model[41] ^
             lfsr_model[42] ^ lfsr_model[43] ^ in_bit ^ (fb_en & ks);
        lfsr_model = {nb, lfsr_model[47:1]};
        return ks;
    endfunction

    function automatic logic [31:0] predict_data_out(input cmd_row_t it);
        logic [31:0] r;
        int          n;
        r = '0;
        case (it.cmd)
            CMD_LOAD:  lfsr_model = it.ld;
            CMD_BIT:   r[0] = lfsr_step(it.data[0], it.fb);
            CMD_BYTE: begin
                for (int i = 0; i < 8; i++)
                    r[i] = lfsr_step(it.data[i], it.fb);
            end
            CMD_WORD: begin
                // most significant byte first, each byte LSB first
                for (int b = 3; b >= 0; b--)
                    for (int i = 0; i < 8; i++)
                        r[8*b+i] = lfsr_step(it.data[8*b+i], it.fb);
            end
            CMD_CBYTE: begin
                for (int i = 0; i < 8; i++)
                    r[i] = lfsr_step(1'b0, 1'b0);
                r[8] = crypto_filter(lfsr_model);   // parity, no clock
                r[8:0] = r[8:0] ^ it.data[8:0];
            end
            CMD_CBITS: begin
                n = (it.cnt > MAX_CIPHER_BITS) ? MAX_CIPHER_BITS : int'(it.cnt);
                for (int i = 0; i < n; i++)
                    r[i] = lfsr_step(1'b0, 1'b0);
                r[7:0] = r[7:0] ^ it.data[7:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- stimulus ----------------

    cmd_row_t directed_tbl [24] = '{
        // zero state: filter and feedback are all zero
        '{CMD_CBYTE,   32'h0000_0000, 1'b0, 4'd0,  48'h0,              1'b1, 32'h0},
        '{CMD_BYTE,    32'h0000_0000, 1'b1, 4'd0,  48'h0,              1'b1, 32'h0},
        '{CMD_WORD,    32'h0000_0000, 1'b1, 4'd0,  48'h0,              1'b1, 32'h0},
        '{CMD_CBYTE,   32'h0000_01FF, 1'b0, 4'd0,  48'h0,              1'b1, 32'h1FF},
        '{CMD_CBYTE,   32'hFFFF_FFFF, 1'b1, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b1, 32'h1FF},
        '{CMD_CBITS,   32'hFFFF_FFFF, 1'b1, 4'd0,  48'h0,              1'b1, 32'hFF},
        '{CMD_LOAD,    32'hFFFF_FFFF, 1'b1, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b1, 32'h0},
        '{CMD_UNUSED6, 32'hFFFF_FFFF, 1'b1, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b1, 32'h0},
        '{CMD_UNUSED7, 32'hFFFF_FFFF, 1'b1, 4'd8,  48'h0,              1'b1, 32'h0},
        '{CMD_BIT,     32'h0000_0001, 1'b1, 4'd0,  48'h0,              1'b0, 32'h0},
        '{CMD_BIT,     32'hFFFF_FFFE, 1'b0, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b0, 32'h0},
        '{CMD_BYTE,    32'h0000_00A5, 1'b0, 4'd0,  48'h0,              1'b0, 32'h0},
        '{CMD_BYTE,    32'hFFFF_FFFF, 1'b1, 4'd0,  48'h0,              1'b0, 32'h0},
        '{CMD_WORD,    32'hFFFF_FFFF, 1'b0, 4'd0,  48'h0,              1'b0, 32'h0},
        '{CMD_WORD,    32'h1234_5678, 1'b1, 4'd0,  48'h0,              1'b0, 32'h0},
        '{CMD_LOAD,    32'h0000_0000, 1'b0, 4'd0,  48'h0,              1'b1, 32'h0},
        '{CMD_LOAD,    32'h0000_0000, 1'b0, 4'd0,  48'hA5A5_5A5A_C3C3, 1'b1, 32'h0},
        '{CMD_CBYTE,   32'h0000_00AB, 1'b1, 4'd0,  48'h0,              1'b0, 32'h0},
        '{CMD_CBITS,   32'h0000_00FF, 1'b0, 4'd8,  48'h0,              1'b0, 32'h0},
        '{CMD_CBITS,   32'h0000_005A, 1'b1, 4'd15, 48'h0,              1'b0, 32'h0},
        '{CMD_CBITS,   32'hFFFF_FF3C, 1'b0, 4'd9,  48'h0,              1'b0, 32'h0},
        '{CMD_CBITS,   32'hFFFF_FF01, 1'b0, 4'd1,  48'h0,              1'b0, 32'h0},
        '{CMD_CBITS,   32'h0000_0123, 1'b0, 4'd0,  48'h0,              1'b1, 32'h23},
        '{CMD_LOAD,    32'h0000_0000, 1'b0, 4'd0,  48'h8000_0000_0001, 1'b1, 32'h0}
    };

    function automatic cmd_row_t random_cmd_row();
        cmd_row_t it;
        int       pick;
        pick = $urandom_range(0, 99);
        it.data   = $urandom;
        it.fb     = 1'($urandom_range(0, 1));
        it.cnt    = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
        it.ld     = {16'($urandom), 32'($urandom)};
        it.pinned = 1'b0;
        it.pinned_out = '0;
        if (pick < 8)       it.cmd = CMD_LOAD;
        else if (pick < 20) it.cmd = CMD_BIT;
        else if (pick < 40) it.cmd = CMD_BYTE;
        else if (pick < 60) it.cmd = CMD_WORD;
        else if (pick < 78) it.cmd = CMD_CBYTE;
        else if (pick < 96) it.cmd = CMD_CBITS;
        else if (pick < 98) it.cmd = CMD_UNUSED6;
        else                it.cmd = CMD_UNUSED7;
        return it;
    endfunction

    // Holds the transfer until accepted, then records the expected result (pinned or predicted)
    task automatic send_cmd(input cmd_row_t it);
        logic [31:0] pred;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.ld, it.cnt, it.fb, it.data};
        s_tuser  <= it.cmd;
        do @(posedge aclk); while (!s_tready);
        pred = predict_data_out(it);
        keystream_q.push_back(it.pinned ? it.pinned_out : pred);
        cmd_hits[it.cmd]++;
        sent_cnt++;
    endtask

    task automatic hold_off(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (keystream_q.size() != 0);
    endtask

    // ---------------- result checking ----------------

    task automatic note_failure(input string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (keystream_q.size() == 0) begin
                note_failure($sformatf("unexpected result %08h", m_tdata));
            end else begin
                want_out = keystream_q.pop_front();
                if (m_tdata !== want_out)
                    note_failure($sformatf("data_out expected %08h actual %08h",
                                           want_out, m_tdata));
            end
        end
    end

    // Result side backpressure: random stall bursts, none in the quiet tail
    initial begin
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    initial begin
        #(12 * 300000);
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial begin
        int gap_odds;
        int drain_wait;
        cmd_row_t it;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        quiet = 1'b0;
        lfsr_model = '0;
        fail_cnt = 0;
        results_seen = 0;
        sent_cnt = 0;
        foreach (cmd_hits[i]) cmd_hits[i] = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_tbl[i]) begin
            if ($urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 12));
            send_cmd(directed_tbl[i]);
        end
        wait_drained();

        for (int k = 0; k < NUM_RANDOM; k++) begin
            // gap density changes every 150 transfers, including none at all
            case ((k / 150) % 3)
                0:       gap_odds = 0;
                1:       gap_odds = 8;
                default: gap_odds = 3;
            endcase
            if (k == NUM_RANDOM / 2)
                wait_drained();
            if (k == NUM_RANDOM - NUM_QUIET)
                quiet = 1'b1;
            if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                hold_off($urandom_range(1, 12));
            it = random_cmd_row();
            send_cmd(it);
        end

        s_tvalid <= 1'b0;
        drain_wait = 0;
        while (keystream_q.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_wait++;
        end
        repeat (8) @(posedge aclk);
        if (keystream_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", keystream_q.size()));

        $display("Sent %0d commands: load %0d, bit %0d, byte %0d, word %0d, cbyte %0d,",
                 sent_cnt, cmd_hits[CMD_LOAD], cmd_hits[CMD_BIT], cmd_hits[CMD_BYTE],
                 cmd_hits[CMD_WORD], cmd_hits[CMD_CBYTE]);
        $display("  cbits %0d, unused codes %0d; %0d results checked, %0d failures",
                 cmd_hits[CMD_CBITS], cmd_hits[CMD_UNUSED6] + cmd_hits[CMD_UNUSED7],
                 results_seen, fail_cnt);
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/c1ks_pkg.sv
rtl/c1ks_core.sv
rtl/crypto1_keystream_engine.sv
rtl/c1ks_checker.sv
sim/crypto1_keystream_engine_tb.sv
